### rtl/delayed_note_release_fifo_top_assert.svh
// Assertion macros for the delayed note release FIFO.
`ifndef DELAYED_NOTE_RELEASE_FIFO_TOP_ASSERT_SVH
`define DELAYED_NOTE_RELEASE_FIFO_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during rst.
`define DNRF_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dnrf assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define DNRF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dnrf assertion failed");
`else
`define DNRF_ASSERT_NOW(lbl, pre, post)
`define DNRF_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### rtl/dnrf_pkg.sv
// Shared types and codes for the delayed note release FIFO.
`timescale 1ns / 1ps
package dnrf_pkg;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  localparam logic [1:0] CFG_RELEASE_DELAY   = 2'd0;
  localparam logic [1:0] CFG_PAD_ENABLE_MASK = 2'd1;

  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_RELEASED = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic        op;
    logic [3:0]  pad;
    logic [6:0]  velocity;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] out_pad;
    logic [6:0] out_velocity;
    logic       send;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [6:0]  velocity;
    logic [31:0] stamp;
  } entry_t;

endpackage

### rtl/dnrf_mem.sv
// Note store: one write port, one registered read port.
`timescale 1ns / 1ps
module dnrf_mem
  import dnrf_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/dnrf_cmp.sv
// Age compare: elapsed time modulo 2^32 against the release delay.
`timescale 1ns / 1ps
module dnrf_cmp
  import dnrf_pkg::*;
(
  input  logic [31:0] now_ms,
  input  logic [31:0] stamp,
  input  logic [15:0] delay,
  output logic        due
);

  logic [31:0] elapsed;

  assign elapsed = now_ms - stamp;
  assign due     = (elapsed >= {16'd0, delay});

endmodule

### rtl/delayed_note_release_fifo_top.sv
// Top level of the delayed note release FIFO: sequencer, pointers, output register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------
//   in       | in_valid / in_stall  | in_data  (op, pad, velocity, now_ms)
//   out      | out_valid / out_stall| out_data (status, pad, velocity, send, last)
//   cfg      | cfg_we               | cfg_index, cfg_wdata
//
// A store passes through S_STORE; a poll runs S_READ and S_CHECK for each entry
// examined, then S_FINISH when a young note or an empty queue ends the scan; all
// paced by the single read port of the note store and the one age compare.
// Items are taken only while the sequencer is idle; results sit in one output
// register, so out_stall back-pressures the sequencer whenever a result is due.
// rst is synchronous: pointers meet (queue empty), registers go to delay 0 and
// all pads enabled. Note store contents are not reset.
`timescale 1ns / 1ps
module delayed_note_release_fifo_top
  import dnrf_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int PAD_COUNT = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

`include "delayed_note_release_fifo_top_assert.svh"

  localparam int AW = $clog2(DEPTH);

  // circular increment, wraps at DEPTH
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    next_slot = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  // configuration registers
  logic [15:0] release_delay;
  logic [15:0] pad_enable_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_delay   <= '0;
      pad_enable_mask <= 16'hFFFF;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RELEASE_DELAY) begin
        release_delay <= cfg_wdata;
      end
      if (cfg_index == CFG_PAD_ENABLE_MASK) begin
        pad_enable_mask <= cfg_wdata;
      end
    end
  end

  // sequencer state
  state_t    state, state_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  in_item_t  req;
  out_item_t pend, pend_next;
  logic      pend_valid, pend_valid_next;

  // store / compare hookup
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;
  logic          due;

  // output register
  logic      push;
  out_item_t push_data;
  logic      out_free;

  logic          accept;
  logic [AW-1:0] head_slot, tail_slot;
  logic          full;
  logic          pad_ok;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign head_slot = next_slot(head);
  assign tail_slot = next_slot(tail);
  assign full      = (head_slot == tail);

  // pads at or above PAD_COUNT are never sent
  assign pad_ok = ({3'd0, mem_rdata.pad} < 7'(PAD_COUNT)) && pad_enable_mask[mem_rdata.pad];

  assign mem_wdata = '{pad: req.pad, velocity: req.velocity, stamp: req.now_ms};

  dnrf_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dnrf_cmp u_cmp (
    .now_ms (req.now_ms),
    .stamp  (mem_rdata.stamp),
    .delay  (release_delay),
    .due    (due)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      pend_valid <= pend_valid_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
    end
    pend <= pend_next;
    if (push) begin
      out_data <= push_data;
    end
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    push            = 1'b0;
    push_data       = '{status: ST_NONE, out_pad: '0, out_velocity: '0,
                        send: 1'b0, last: 1'b1};
    mem_we          = 1'b0;
    mem_waddr       = head_slot;
    mem_re          = 1'b0;
    mem_raddr       = tail_slot;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_data.op == OP_STORE) ? S_STORE : S_READ;
        end
      end
      S_STORE: begin
        if (out_free) begin
          push             = 1'b1;
          push_data.status = full ? ST_DROPPED : ST_STORED;
          if (!full) begin
            mem_we    = 1'b1;
            head_next = head_slot;
          end
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        // empty queue ends the scan
        if (head == tail) begin
          state_next = S_FINISH;
        end else begin
          mem_re     = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!due) begin
          state_next = S_FINISH;
        end else if (!pend_valid || out_free) begin
          // older release goes out now; it is known not to be the last
          if (pend_valid) begin
            push           = 1'b1;
            push_data      = pend;
            push_data.last = 1'b0;
          end
          pend_next = '{status: ST_RELEASED, out_pad: mem_rdata.pad,
                        out_velocity: mem_rdata.velocity, send: pad_ok, last: 1'b0};
          pend_valid_next = 1'b1;
          tail_next       = tail_slot;
          state_next      = S_READ;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          push = 1'b1;
          if (pend_valid) begin
            push_data      = pend;
            push_data.last = 1'b1;
          end
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `DNRF_ASSERT_NOW(a_no_push_when_held, out_valid && out_stall, !push)
  `DNRF_ASSERT_NOW(a_check_nonempty, state == S_CHECK, head != tail)
  `DNRF_ASSERT_NEXT(a_last_ends_item, push && push_data.last, state == S_IDLE)
  `DNRF_ASSERT_NOW(a_pend_in_poll, pend_valid, state == S_READ || state == S_CHECK || state == S_FINISH)

endmodule

### tb/testbench.sv
// Self-checking testbench for the delayed note release FIFO top level.
`timescale 1ns / 1ps
module testbench;
  import dnrf_pkg::*;

  localparam int SETTLE_CYCLES  = 8;     // block returns to idle well within this
  localparam int END_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 50;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_RELEASE_DELAY;
  logic [15:0] cfg_wdata = '0;

  delayed_note_release_fifo_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the note queue and registers, updated as items are accepted.
  logic [3:0]  note_pad   [16];
  logic [6:0]  note_vel   [16];
  logic [31:0] note_stamp [16];
  logic [3:0]  head_ptr = '0;
  logic [3:0]  tail_ptr = '0;
  logic [15:0] delay_ms = 16'd0;
  logic [15:0] pad_mask = 16'hFFFF;

  out_item_t pending_reports[$];   // results owed by the block, oldest first

  int mismatches = 0;
  int n_items = 0, n_stores = 0, n_polls = 0, n_released = 0, n_dropped = 0;
  int n_settings = 0;
  bit in_idle_on  = 1'b0;
  bit out_idle_on = 1'b0;

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_item(logic op, logic [3:0] pad, logic [6:0] vel,
                                         logic [31:0] stamp);
    in_item_t it;
    it.op       = op;
    it.pad      = pad;
    it.velocity = vel;
    it.now_ms   = stamp;
    return it;
  endfunction

  // Works out the results that one accepted item causes.
  task automatic predict_release(input in_item_t it);
    logic [3:0]  slot;
    logic [31:0] elapsed;
    out_item_t   r;
    out_item_t   held;
    bit          have_held;
    have_held = 1'b0;
    n_items++;
    r = '0;
    if (it.op == OP_STORE) begin
      n_stores++;
      slot   = head_ptr + 4'd1;
      r.last = 1'b1;
      if (slot == tail_ptr) begin
        // queue full: the new note is dropped, nothing moves
        r.status = ST_DROPPED;
        n_dropped++;
      end else begin
        note_pad[slot]   = it.pad;
        note_vel[slot]   = it.velocity;
        note_stamp[slot] = it.now_ms;
        head_ptr         = slot;
        r.status         = ST_STORED;
      end
      pending_reports.push_back(r);
    end else begin
      n_polls++;
      while (head_ptr != tail_ptr) begin
        slot    = tail_ptr + 4'd1;
        elapsed = it.now_ms - note_stamp[slot];   // wraps mod 2^32
        if (elapsed < {16'd0, delay_ms}) break;
        tail_ptr       = slot;
        r              = '0;
        r.status       = ST_RELEASED;
        r.out_pad      = note_pad[slot];
        r.out_velocity = note_vel[slot];
        r.send         = pad_mask[note_pad[slot]];
        if (have_held) pending_reports.push_back(held);
        held      = r;
        have_held = 1'b1;
        n_released++;
      end
      if (have_held) begin
        held.last = 1'b1;
        pending_reports.push_back(held);
      end else begin
        r        = '0;
        r.status = ST_NONE;
        r.last   = 1'b1;
        pending_reports.push_back(r);
      end
    end
  endtask

  // Called right after a rising edge; leaves in_valid high when gap is zero.
  task automatic send_note(input in_item_t it, input int gap);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_release(it);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RELEASE_DELAY:   delay_ms = val;
      CFG_PAD_ENABLE_MASK: pad_mask = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [15:0] dly, input logic [15:0] mask);
    wait_for_results();
    write_reg(CFG_RELEASE_DELAY, dly);
    write_reg(CFG_PAD_ENABLE_MASK, mask);
    n_settings++;
  endtask

  // Reset values: empty poll, zero delay releases everything at the next poll.
  task automatic test_empty_and_defaults();
    n_settings++;
    send_note(make_item(OP_POLL, 4'd0, 7'd0, 32'd0), 1);
    send_note(make_item(OP_STORE, 4'd0, 7'd0, 32'd5), 0);
    send_note(make_item(OP_STORE, 4'd15, 7'd127, 32'd6), 2);
    send_note(make_item(OP_POLL, 4'd15, 7'd127, 32'd6), 0);
  endtask

  // Fill past capacity with stamps that cross the 2^32 wrap, then drain in two
  // polls after one that finds nothing old enough.
  task automatic test_fill_overflow_wrap();
    logic [31:0] t0;
    logic [6:0]  vel;
    t0 = 32'hFFFF_FFF8;
    set_registers(16'd1000, 16'hA5A5);
    for (int i = 0; i < 16; i++) begin
      vel = (i == 0) ? 7'd127 : (i == 1) ? 7'd0 : 7'($urandom_range(0, 127));
      send_note(make_item(OP_STORE, 4'(15 - i), vel, t0 + 32'(i)), 0);
    end
    send_note(make_item(OP_POLL, 4'd0, 7'd0, t0 + 32'd500), 0);
    send_note(make_item(OP_POLL, 4'd0, 7'd0, t0 + 32'd1005), 0);
    send_note(make_item(OP_POLL, 4'd0, 7'd0, t0 + 32'd1014), 0);
  endtask

  // Well-formed traffic on a moving clock, with some fully random items mixed in.
  task automatic run_random_phase(input logic [15:0] dly, input logic [15:0] mask,
                                  input bit idle);
    logic [31:0] t_now;
    int unsigned step;
    int          r;
    in_item_t    it;
    set_registers(dly, mask);
    in_idle_on  = idle;
    out_idle_on = idle;
    t_now = $urandom();
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      // hold off once per phase until the block has caught up
      if (k == PHASE_ITEMS / 2) wait_for_results();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        it = make_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       7'($urandom_range(0, 127)), $urandom());
      end else begin
        if ($urandom_range(0, 9) == 0) step = int'(dly) + $urandom_range(0, 3);
        else step = $urandom_range(0, int'(dly) / 8 + 2);
        t_now = t_now + step;
        it = make_item((r < 55) ? OP_STORE : OP_POLL, 4'($urandom_range(0, 15)),
                       7'($urandom_range(0, 127)), t_now);
      end
      send_note(it, pick_gap(in_idle_on));
    end
  endtask

  task automatic test_random_phases();
    run_random_phase(16'd0, 16'hFFFF, 1'b0);
    run_random_phase(16'hFFFF, 16'h0000, 1'b1);
    run_random_phase(16'($urandom_range(1, 300)), 16'($urandom_range(0, 65535)), 1'b1);
    run_random_phase(16'($urandom_range(1000, 20000)), 16'($urandom_range(0, 65535)), 1'b1);
  endtask

  // Receiver back-pressure.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || !out_idle_on) stall_left = 0;
    else if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 3) == 0) stall_left = pick_gap(1'b1);
    out_stall <= (stall_left != 0);
  end

  // Result checker: every accepted result against the oldest expectation.
  out_item_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result status=%0d pad=%0d vel=%0d send=%0b last=%0b",
                   $time, out_data.status, out_data.out_pad, out_data.out_velocity,
                   out_data.send, out_data.last);
      end else begin
        want = pending_reports.pop_front();
        if (out_data.status !== want.status || out_data.out_pad !== want.out_pad ||
            out_data.out_velocity !== want.out_velocity ||
            out_data.send !== want.send || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch exp status=%0d pad=%0d vel=%0d send=%0b last=%0b, got status=%0d pad=%0d vel=%0d send=%0b last=%0b",
                     $time, want.status, want.out_pad, want.out_velocity, want.send,
                     want.last, out_data.status, out_data.out_pad,
                     out_data.out_velocity, out_data.send, out_data.last);
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_reports.size());
        $display("** delayed_note_release_fifo_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_defaults();
    test_fill_overflow_wrap();
    test_random_phases();
    wait_for_results();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) mismatches++;
    $display("Ran %0d items (%0d stores, %0d polls) over %0d register settings.",
             n_items, n_stores, n_polls, n_settings);
    $display("Saw %0d notes released and %0d dropped on a full queue; %0d mismatches.",
             n_released, n_dropped, mismatches);
    if (mismatches == 0) begin
      $display("** delayed_note_release_fifo_top: PASSED **");
    end else begin
      $display("** delayed_note_release_fifo_top: FAILED **");
    end
    $finish;
  end

endmodule
